>>> rtl/rhcs_pkg.sv
// ----------------------------------------------------------------------------
// rhcs_pkg
// Shared types and constants for the closest valid ray-hit selector.
// ----------------------------------------------------------------------------
package rhcs_pkg;

  localparam int COORD_W    = 24;
  localparam int NORMAL_W   = 16;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_DIR_X   = 3'd3,
    CFG_DIR_Y   = 3'd4,
    CFG_DIR_Z   = 3'd5
  } cfg_idx_t;

  localparam logic signed [NORMAL_W-1:0] DIR_Y_RST = NORMAL_W'(-16384);

  typedef struct packed {
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [NORMAL_W-1:0] dir_x;
    logic signed [NORMAL_W-1:0] dir_y;
    logic signed [NORMAL_W-1:0] dir_z;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  hit_x;
    logic signed [COORD_W-1:0]  hit_y;
    logic signed [COORD_W-1:0]  hit_z;
    logic signed [NORMAL_W-1:0] surf_nx;
    logic signed [NORMAL_W-1:0] surf_ny;
    logic signed [NORMAL_W-1:0] surf_nz;
    logic                       is_object_hit;
    logic                       has_point;
    logic                       has_normal;
    logic                       back_culled;
    logic                       front_culled;
    logic                       last_hit;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [COORD_W-1:0]  best_x;
    logic signed [COORD_W-1:0]  best_y;
    logic signed [COORD_W-1:0]  best_z;
    logic signed [NORMAL_W-1:0] best_nx;
    logic signed [NORMAL_W-1:0] best_ny;
    logic signed [NORMAL_W-1:0] best_nz;
  } out_item_t;

  // classified candidate handed from front to back
  typedef struct packed {
    logic                       ok;
    logic                       last_hit;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [NORMAL_W-1:0] nx;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nz;
    logic [DIST_W-1:0]          range_sq;
  } cand_t;

endpackage

>>> rtl/ray_hit_closest_valid_select.sv
// ----------------------------------------------------------------------------
// ray_hit_closest_valid_select
// Selects the valid ray-hit candidate nearest to the ray start per query.
// ----------------------------------------------------------------------------
//  channel | ports                           | beat taken when
//  --------+---------------------------------+-------------------------------
//  input   | in_push, in_full, in_data       | in_push && !in_full
//  result  | out_empty, out_pop, out_data    | out_pop && !out_empty
//  config  | cfg_we, cfg_idx, cfg_wdata      | cfg_we
//
//  One candidate per cycle sustained while in_full is low. A taken candidate
//  passes the front stage a and stage b registers into the mid queue; the back
//  end pops it from there, and the pop of a last beat also writes the result
//  of its query into the result queue, from which it shows on out_data.
//  The best-so-far compare in the back end feeds back on its own registers.
//  in_full rises when QUEUE_DEPTH beats sit in the front pipe and mid queue.
//  A last beat waits in the mid queue while the result queue is full.
//  Reset (rst_n low, synchronous) empties all queues and restores registers.
// ----------------------------------------------------------------------------
module ray_hit_closest_valid_select #(
  parameter int QUEUE_DEPTH = 8,
  parameter int RES_DEPTH   = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  rhcs_pkg::in_item_t                  in_data,
  output logic                                out_empty,
  input  logic                                out_pop,
  output rhcs_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [rhcs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rhcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rhcs_pkg::cfg_t      cfg_r, cfg_nxt;
  logic [CNT_W-1:0]    inflight_r, inflight_nxt;
  logic                in_accept;
  logic                cand_valid, mid_empty, mid_full, mid_pop;
  rhcs_pkg::cand_t     cand_data, mid_data;
  logic                res_push, res_full;
  rhcs_pkg::out_item_t res_data;

  // config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        rhcs_pkg::CFG_START_X: cfg_nxt.start_x = cfg_wdata[rhcs_pkg::COORD_W-1:0];
        rhcs_pkg::CFG_START_Y: cfg_nxt.start_y = cfg_wdata[rhcs_pkg::COORD_W-1:0];
        rhcs_pkg::CFG_START_Z: cfg_nxt.start_z = cfg_wdata[rhcs_pkg::COORD_W-1:0];
        rhcs_pkg::CFG_DIR_X:   cfg_nxt.dir_x   = cfg_wdata[rhcs_pkg::NORMAL_W-1:0];
        rhcs_pkg::CFG_DIR_Y:   cfg_nxt.dir_y   = cfg_wdata[rhcs_pkg::NORMAL_W-1:0];
        rhcs_pkg::CFG_DIR_Z:   cfg_nxt.dir_z   = cfg_wdata[rhcs_pkg::NORMAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x <= '0;
      cfg_r.start_y <= '0;
      cfg_r.start_z <= '0;
      cfg_r.dir_x   <= '0;
      cfg_r.dir_y   <= rhcs_pkg::DIR_Y_RST;
      cfg_r.dir_z   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // credit count covers the front pipe and the mid queue
  assign in_full   = (inflight_r == CNT_W'(QUEUE_DEPTH));
  assign in_accept = in_push && !in_full;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_accept && !mid_pop) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (mid_pop && !in_accept) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  rhcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_accept),
    .in_data    (in_data),
    .cand_valid (cand_valid),
    .cand_data  (cand_data)
  );

  rhcs_fifo #(
    .WIDTH ($bits(rhcs_pkg::cand_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cand_valid),
    .push_data (cand_data),
    .pop       (mid_pop),
    .pop_data  (mid_data),
    .empty     (mid_empty),
    .full      (mid_full)
  );

  rhcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_empty (mid_empty),
    .cand_data  (mid_data),
    .cand_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  rhcs_fifo #(
    .WIDTH ($bits(rhcs_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty),
    .full      (res_full)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(QUEUE_DEPTH))
    else $error("in-flight count above queue depth");

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cand_valid && mid_full))
    else $error("candidate pushed into full mid queue");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result pushed into full result queue");

  a_pop_needs_credit: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> (inflight_r != '0))
    else $error("mid queue pop without in-flight beat");

endmodule

>>> rtl/rhcs_fifo.sv
// ----------------------------------------------------------------------------
// rhcs_fifo
// Small register-based queue, first word always visible on pop_data.
// ----------------------------------------------------------------------------
module rhcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/rhcs_front.sv
// ----------------------------------------------------------------------------
// rhcs_front
// Two-stage classifier: distance terms and dot products, then normal
// orientation, acceptance test and squared distance.
// ----------------------------------------------------------------------------
module rhcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rhcs_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  rhcs_pkg::in_item_t in_data,
  output logic              cand_valid,
  output rhcs_pkg::cand_t   cand_data
);

  localparam int CW    = rhcs_pkg::COORD_W;
  localparam int NW    = rhcs_pkg::NORMAL_W;
  localparam int DOT_W = 2 * NW + 3;

  function automatic logic signed [NW-1:0] neg_sat(input logic signed [NW-1:0] v);
    logic signed [NW-1:0] r;
    if (v == {1'b1, {(NW-1){1'b0}}}) begin
      r = {1'b0, {(NW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // stage a
  logic                   a_vld_r;
  logic                   a_cand_r, a_bc_r, a_fc_r, a_last_r;
  logic signed [CW-1:0]   a_p_r    [3];
  logic signed [NW-1:0]   a_n_r    [3];
  logic [CW-1:0]          a_abs_r  [3];
  logic signed [2*NW-1:0] a_prod_r [3];

  logic signed [CW-1:0]   hit      [3];
  logic signed [NW-1:0]   nrm      [3];
  logic signed [CW-1:0]   start    [3];
  logic signed [NW-1:0]   dir      [3];
  logic signed [CW:0]     diff     [3];
  logic [CW:0]            diff_neg [3];
  logic [CW-1:0]          abs_nxt  [3];
  logic signed [2*NW-1:0] prod_nxt [3];

  // stage b
  logic                   b_vld_r, b_ok_r, b_last_r;
  logic signed [CW-1:0]   b_p_r  [3];
  logic signed [NW-1:0]   b_n_r  [3];
  logic [2*CW-1:0]        b_sq_r [3];

  logic signed [DOT_W-1:0] dot, corr, dot_flip, dot_fin;
  logic                    flip, dot_pos, accept, dir_up;
  logic signed [NW-1:0]    n_orient [3];
  logic [2*CW-1:0]         sq_nxt   [3];

  always_comb begin
    hit[0]   = in_data.hit_x;   hit[1]   = in_data.hit_y;   hit[2]   = in_data.hit_z;
    nrm[0]   = in_data.surf_nx; nrm[1]   = in_data.surf_ny; nrm[2]   = in_data.surf_nz;
    start[0] = cfg.start_x;     start[1] = cfg.start_y;     start[2] = cfg.start_z;
    dir[0]   = cfg.dir_x;       dir[1]   = cfg.dir_y;       dir[2]   = cfg.dir_z;
    for (int i = 0; i < 3; i++) begin
      diff[i]     = $signed({start[i][CW-1], start[i]}) - $signed({hit[i][CW-1], hit[i]});
      diff_neg[i] = -diff[i];
      abs_nxt[i]  = diff[i][CW] ? diff_neg[i][CW-1:0] : diff[i][CW-1:0];
      prod_nxt[i] = $signed(dir[i]) * $signed(nrm[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_cand_r <= !in_data.is_object_hit && in_data.has_point && in_data.has_normal;
    a_bc_r   <= in_data.back_culled;
    a_fc_r   <= in_data.front_culled;
    a_last_r <= in_data.last_hit;
    for (int i = 0; i < 3; i++) begin
      a_p_r[i]    <= hit[i];
      a_n_r[i]    <= nrm[i];
      a_abs_r[i]  <= abs_nxt[i];
      a_prod_r[i] <= prod_nxt[i];
    end
  end

  always_comb begin
    dot  = DOT_W'(a_prod_r[0]) + DOT_W'(a_prod_r[1]) + DOT_W'(a_prod_r[2]);
    // a saturated negation is one short of the true negation, so the
    // flipped dot gives back dir for each saturated component
    corr = '0;
    for (int i = 0; i < 3; i++) begin
      if (a_n_r[i] == {1'b1, {(NW-1){1'b0}}}) begin
        corr = corr + DOT_W'(dir[i]);
      end
    end
    dot_flip = -dot - corr;
    dot_pos  = !dot[DOT_W-1] && (dot != '0);
    flip     = (!a_bc_r && !a_fc_r) ? dot_pos : a_fc_r;
    dot_fin  = flip ? dot_flip : dot;
    dir_up   = !cfg.dir_y[NW-1] && (cfg.dir_y != '0);
    accept   = dir_up ? (!dot_fin[DOT_W-1] && (dot_fin != '0)) : dot_fin[DOT_W-1];
    for (int i = 0; i < 3; i++) begin
      n_orient[i] = flip ? neg_sat(a_n_r[i]) : a_n_r[i];
      sq_nxt[i]   = (2*CW)'(a_abs_r[i]) * (2*CW)'(a_abs_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_ok_r   <= a_cand_r && accept;
    b_last_r <= a_last_r;
    for (int i = 0; i < 3; i++) begin
      b_p_r[i]  <= a_p_r[i];
      b_n_r[i]  <= n_orient[i];
      b_sq_r[i] <= sq_nxt[i];
    end
  end

  always_comb begin
    cand_valid         = b_vld_r;
    cand_data.ok       = b_ok_r;
    cand_data.last_hit = b_last_r;
    cand_data.x        = b_p_r[0];
    cand_data.y        = b_p_r[1];
    cand_data.z        = b_p_r[2];
    cand_data.nx       = b_n_r[0];
    cand_data.ny       = b_n_r[1];
    cand_data.nz       = b_n_r[2];
    cand_data.range_sq = rhcs_pkg::DIST_W'(b_sq_r[0]) + rhcs_pkg::DIST_W'(b_sq_r[1])
                       + rhcs_pkg::DIST_W'(b_sq_r[2]);
  end

endmodule

>>> rtl/rhcs_back.sv
// ----------------------------------------------------------------------------
// rhcs_back
// Keeps the nearest accepted candidate of the running query and emits it
// on the last beat of the query.
// ----------------------------------------------------------------------------
module rhcs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cand_empty,
  input  rhcs_pkg::cand_t     cand_data,
  output logic                cand_pop,
  input  logic                res_full,
  output logic                res_push,
  output rhcs_pkg::out_item_t res_data
);

  logic                                  have_best_r, have_best_nxt;
  logic [rhcs_pkg::DIST_W-1:0]           best_dist_r;
  logic signed [rhcs_pkg::COORD_W-1:0]   best_x_r, best_y_r, best_z_r;
  logic signed [rhcs_pkg::NORMAL_W-1:0]  best_nx_r, best_ny_r, best_nz_r;
  logic                                  upd, found;

  always_comb begin
    upd      = cand_data.ok && (!have_best_r || (cand_data.range_sq < best_dist_r));
    cand_pop = !cand_empty && (!cand_data.last_hit || !res_full);
    res_push = cand_pop && cand_data.last_hit;
    found    = have_best_r || upd;

    res_data.found   = found;
    res_data.best_x  = !found ? '0 : (upd ? cand_data.x  : best_x_r);
    res_data.best_y  = !found ? '0 : (upd ? cand_data.y  : best_y_r);
    res_data.best_z  = !found ? '0 : (upd ? cand_data.z  : best_z_r);
    res_data.best_nx = !found ? '0 : (upd ? cand_data.nx : best_nx_r);
    res_data.best_ny = !found ? '0 : (upd ? cand_data.ny : best_ny_r);
    res_data.best_nz = !found ? '0 : (upd ? cand_data.nz : best_nz_r);

    have_best_nxt = have_best_r;
    if (cand_pop) begin
      if (cand_data.last_hit) begin
        have_best_nxt = 1'b0;
      end else if (upd) begin
        have_best_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else begin
      have_best_r <= have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_pop && upd) begin
      best_dist_r <= cand_data.range_sq;
      best_x_r    <= cand_data.x;
      best_y_r    <= cand_data.y;
      best_z_r    <= cand_data.z;
      best_nx_r   <= cand_data.nx;
      best_ny_r   <= cand_data.ny;
      best_nz_r   <= cand_data.nz;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !have_best_r)
    else $error("best not cleared after end of query");

  a_found_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !cand_data.ok) |-> (res_data.found == have_best_r))
    else $error("found flag mismatch on non-accepted last beat");

endmodule

>>> tb/ray_hit_closest_valid_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_hit_closest_valid_select_tb
// Streams ray-hit candidates through the selector under several ray setups.
// A local predictor tracks the nearest accepted hit of each query; every result
// beat is compared field by field with the typed-in or predicted query result.
// ----------------------------------------------------------------------------
module ray_hit_closest_valid_select_tb;

  localparam int CW          = rhcs_pkg::COORD_W;
  localparam int NW          = rhcs_pkg::NORMAL_W;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 110;

  // candidate flag bits, in the order {object, point, normal, back, front, last}
  localparam logic [5:0] F_OBJ   = 6'b100000;
  localparam logic [5:0] F_PT    = 6'b010000;
  localparam logic [5:0] F_NRM   = 6'b001000;
  localparam logic [5:0] F_BACK  = 6'b000100;
  localparam logic [5:0] F_FRONT = 6'b000010;
  localparam logic [5:0] F_LAST  = 6'b000001;
  localparam logic [5:0] F_VALID = F_PT | F_NRM;

  localparam logic signed [NW-1:0] NRM_MIN = {1'b1, {(NW-1){1'b0}}};
  localparam logic signed [NW-1:0] NRM_MAX = {1'b0, {(NW-1){1'b1}}};

  typedef struct {
    rhcs_pkg::in_item_t  cand;
    bit                  typed;
    rhcs_pkg::out_item_t want;
  } probe_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_push;
  logic                            in_full;
  rhcs_pkg::in_item_t              in_data;
  logic                            out_empty;
  logic                            out_pop;
  rhcs_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [rhcs_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [rhcs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // typed-in expectation travelling alongside the current input beat
  logic                row_typed;
  rhcs_pkg::out_item_t row_want;

  // predictor state
  rhcs_pkg::cfg_t       ray_cfg;
  bit                   best_found;
  logic signed [CW-1:0] best_pt[3];
  logic signed [NW-1:0] best_nrm[3];

  rhcs_pkg::out_item_t query_results_q[$];
  probe_t              probe_q[$];
  rhcs_pkg::in_item_t  last_cand;
  int                  errors;
  int                  quiet_cycles;
  bit                  calm;
  bit                  hold_pending;

  ray_hit_closest_valid_select u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned dist_sq(input logic signed [CW-1:0] px,
                                              input logic signed [CW-1:0] py,
                                              input logic signed [CW-1:0] pz);
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    longint dx;
    longint dy;
    longint dz;
    sx = ray_cfg.start_x;
    sy = ray_cfg.start_y;
    sz = ray_cfg.start_z;
    dx = longint'(sx) - longint'(px);
    dy = longint'(sy) - longint'(py);
    dz = longint'(sz) - longint'(pz);
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  function automatic longint ray_dot(input logic signed [NW-1:0] nx,
                                     input logic signed [NW-1:0] ny,
                                     input logic signed [NW-1:0] nz);
    logic signed [NW-1:0] dx;
    logic signed [NW-1:0] dy;
    logic signed [NW-1:0] dz;
    dx = ray_cfg.dir_x;
    dy = ray_cfg.dir_y;
    dz = ray_cfg.dir_z;
    return longint'(dx) * longint'(nx) + longint'(dy) * longint'(ny)
         + longint'(dz) * longint'(nz);
  endfunction

  function automatic logic signed [NW-1:0] flip_sat(input logic signed [NW-1:0] v);
    if (v == NRM_MIN) return NRM_MAX;
    return -v;
  endfunction

  // returns 1 when the candidate closes a query, with the query result in r
  function automatic bit pick_closest(input rhcs_pkg::in_item_t c,
                                      output rhcs_pkg::out_item_t r);
    logic signed [NW-1:0] n[3];
    logic signed [NW-1:0] dy;
    longint d;
    bit flip;
    bit ok;
    n[0] = c.surf_nx;
    n[1] = c.surf_ny;
    n[2] = c.surf_nz;
    dy = ray_cfg.dir_y;
    r = '0;
    if (!c.is_object_hit && c.has_point && c.has_normal &&
        (!best_found || dist_sq(c.hit_x, c.hit_y, c.hit_z)
                        < dist_sq(best_pt[0], best_pt[1], best_pt[2]))) begin
      if (!c.back_culled && !c.front_culled) flip = ray_dot(n[0], n[1], n[2]) > 0;
      else flip = c.front_culled;
      if (flip) begin
        for (int i = 0; i < 3; i++) n[i] = flip_sat(n[i]);
      end
      d = ray_dot(n[0], n[1], n[2]);
      ok = (dy > 0) ? (d > 0) : (d < 0);
      if (ok) begin
        best_found = 1'b1;
        best_pt[0] = c.hit_x;
        best_pt[1] = c.hit_y;
        best_pt[2] = c.hit_z;
        best_nrm   = n;
      end
    end
    if (!c.last_hit) return 1'b0;
    if (best_found) begin
      r.found   = 1'b1;
      r.best_x  = best_pt[0];
      r.best_y  = best_pt[1];
      r.best_z  = best_pt[2];
      r.best_nx = best_nrm[0];
      r.best_ny = best_nrm[1];
      r.best_nz = best_nrm[2];
    end
    best_found = 1'b0;
    for (int i = 0; i < 3; i++) begin
      best_pt[i]  = '0;
      best_nrm[i] = '0;
    end
    return 1'b1;
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void cmp_field(input string name, input longint want,
                                    input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(input rhcs_pkg::out_item_t got);
    rhcs_pkg::out_item_t want;
    if (query_results_q.size() == 0) begin
      $error("result beat with nothing pending: found %0d", got.found);
      errors++;
      return;
    end
    want = query_results_q.pop_front();
    cmp_field("found",   want.found,   got.found);
    cmp_field("best_x",  want.best_x,  got.best_x);
    cmp_field("best_y",  want.best_y,  got.best_y);
    cmp_field("best_z",  want.best_z,  got.best_z);
    cmp_field("best_nx", want.best_nx, got.best_nx);
    cmp_field("best_ny", want.best_ny, got.best_ny);
    cmp_field("best_nz", want.best_nz, got.best_nz);
  endtask

  rhcs_pkg::out_item_t pred_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_push && !in_full) begin
        if (pick_closest(in_data, pred_res)) begin
          query_results_q.push_back(row_typed ? row_want : pred_res);
        end
      end
      if (out_pop && !out_empty) check_result(out_data);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("ray_hit_closest_valid_select_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : drain
    out_pop <= 1'b0;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_pop <= calm || ($urandom_range(99) >= 12);
      @(posedge clk);
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic rhcs_pkg::in_item_t mk(input int x, input int y, input int z,
                                            input int nx, input int ny, input int nz,
                                            input logic [5:0] fl);
    rhcs_pkg::in_item_t c;
    c.hit_x   = CW'(x);
    c.hit_y   = CW'(y);
    c.hit_z   = CW'(z);
    c.surf_nx = NW'(nx);
    c.surf_ny = NW'(ny);
    c.surf_nz = NW'(nz);
    {c.is_object_hit, c.has_point, c.has_normal,
     c.back_culled, c.front_culled, c.last_hit} = fl;
    return c;
  endfunction

  function automatic rhcs_pkg::out_item_t hit_res(input bit f, input int x, input int y,
                                                  input int z, input int nx, input int ny,
                                                  input int nz);
    rhcs_pkg::out_item_t r;
    r.found   = f;
    r.best_x  = CW'(x);
    r.best_y  = CW'(y);
    r.best_z  = CW'(z);
    r.best_nx = NW'(nx);
    r.best_ny = NW'(ny);
    r.best_nz = NW'(nz);
    return r;
  endfunction

  function automatic logic [NW-1:0] rand_norm();
    case ($urandom_range(9))
      0: return NRM_MIN;
      1: return NRM_MAX;
      2: return '0;
      default: return NW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] s);
    int off;
    off = int'($urandom_range(8191)) - 4096;
    return s + CW'(off);
  endfunction

  function automatic rhcs_pkg::in_item_t rand_cand(input bit last);
    rhcs_pkg::in_item_t c;
    int kind;
    kind = $urandom_range(99);
    if (kind < 20) begin
      c.hit_x = CW'($urandom);
      c.hit_y = CW'($urandom);
      c.hit_z = CW'($urandom);
    end else if (kind < 30) begin
      // same point again, so distance ties come up
      c.hit_x = last_cand.hit_x;
      c.hit_y = last_cand.hit_y;
      c.hit_z = last_cand.hit_z;
    end else begin
      c.hit_x = near_coord(ray_cfg.start_x);
      c.hit_y = near_coord(ray_cfg.start_y);
      c.hit_z = near_coord(ray_cfg.start_z);
    end
    c.surf_nx       = rand_norm();
    c.surf_ny       = rand_norm();
    c.surf_nz       = rand_norm();
    c.is_object_hit = $urandom_range(99) < 8;
    c.has_point     = $urandom_range(99) < 94;
    c.has_normal    = $urandom_range(99) < 94;
    c.back_culled   = $urandom_range(99) < 30;
    c.front_culled  = $urandom_range(99) < 30;
    c.last_hit      = last;
    last_cand = c;
    return c;
  endfunction

  task automatic send_item(input rhcs_pkg::in_item_t c, input bit typed,
                           input rhcs_pkg::out_item_t want);
    while (!calm && $urandom_range(99) < 12) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push   <= 1'b1;
    in_data   <= c;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (in_full);
  endtask

  task automatic load_setup(input rhcs_pkg::cfg_t s);
    rhcs_pkg::cfg_idx_t idx;
    for (int i = 0; i <= int'(rhcs_pkg::CFG_DIR_Z); i++) begin
      idx = rhcs_pkg::cfg_idx_t'(i);
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        rhcs_pkg::CFG_START_X: cfg_wdata <= s.start_x;
        rhcs_pkg::CFG_START_Y: cfg_wdata <= s.start_y;
        rhcs_pkg::CFG_START_Z: cfg_wdata <= s.start_z;
        rhcs_pkg::CFG_DIR_X:   cfg_wdata <= rhcs_pkg::CFG_DATA_W'(s.dir_x);
        rhcs_pkg::CFG_DIR_Y:   cfg_wdata <= rhcs_pkg::CFG_DATA_W'(s.dir_y);
        default:               cfg_wdata <= rhcs_pkg::CFG_DATA_W'(s.dir_z);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ray_cfg = s;
  endtask

  task automatic run_queries(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) send_item(rand_cand(k == len - 1), 1'b0, '0);
      sent += len;
    end
    in_push <= 1'b0;
  endtask

  rhcs_pkg::cfg_t setups[8];

  initial begin : main
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    row_typed <= 1'b0;
    row_want  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    errors       = 0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    last_cand    = '0;
    ray_cfg      = '{start_x: '0, start_y: '0, start_z: '0,
                     dir_x: '0, dir_y: rhcs_pkg::DIR_Y_RST, dir_z: '0};
    best_found   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      best_pt[i]  = '0;
      best_nrm[i] = '0;
    end

    // setup 0 is the reset state and is never written
    setups[0] = ray_cfg;
    setups[1] = '{start_x: 24'h7fffff, start_y: 24'h7fffff, start_z: 24'h7fffff,
                  dir_x: NRM_MAX, dir_y: NRM_MAX, dir_z: NRM_MAX};
    setups[2] = '{start_x: 24'h800000, start_y: 24'h800000, start_z: 24'h800000,
                  dir_x: NRM_MIN, dir_y: NRM_MIN, dir_z: NRM_MIN};
    // horizontal ray falls under the downward test
    setups[3] = '{start_x: '0, start_y: '0, start_z: '0,
                  dir_x: 16'sd16384, dir_y: '0, dir_z: '0};
    setups[4] = '{start_x: CW'($urandom), start_y: CW'($urandom),
                  start_z: CW'($urandom), dir_x: '0, dir_y: 16'sd16384, dir_z: '0};
    for (int i = 5; i < 8; i++) begin
      setups[i] = '{start_x: CW'($urandom), start_y: CW'($urandom),
                    start_z: CW'($urandom), dir_x: NW'($urandom),
                    dir_y: NW'($urandom), dir_z: NW'($urandom)};
    end

    // directed rows under the reset ray: start at origin, pointing down
    probe_q.push_back('{mk(0, 0, 0, 0, 0, 0, F_OBJ | F_VALID | F_LAST),
                        1'b1, hit_res(0, 0, 0, 0, 0, 0, 0)});
    probe_q.push_back('{mk(4096, 8192, -4096, 0, 16384, 0, F_VALID | F_LAST),
                        1'b1, hit_res(1, 4096, 8192, -4096, 0, 16384, 0)});
    probe_q.push_back('{mk(8388607, -8388608, 8388607, 0, -32768, 0,
                           F_VALID | F_FRONT | F_LAST),
                        1'b1, hit_res(1, 8388607, -8388608, 8388607, 0, 32767, 0)});
    probe_q.push_back('{mk(4096, 0, 0, 0, -16384, 0, F_VALID | F_LAST), 1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 0, -16384, 0, F_VALID | F_BACK | F_LAST),
                        1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 16384, 0, -16384, F_VALID | F_LAST), 1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 0, -16384, 0,
                           F_VALID | F_BACK | F_FRONT | F_LAST), 1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 0, 16384, 0, F_NRM | F_LAST), 1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 0, 16384, 0, F_PT | F_LAST), 1'b0, '0});
    // far, nearer, farther, then a tie that must not replace
    probe_q.push_back('{mk(40960, 0, 0, 0, 16384, 0, F_VALID), 1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 0, 16384, 100, F_VALID), 1'b0, '0});
    probe_q.push_back('{mk(8192, 0, 0, 0, 16384, 0, F_VALID), 1'b0, '0});
    probe_q.push_back('{mk(-4096, 0, 0, 0, 8192, 0, F_VALID | F_LAST), 1'b0, '0});
    // nearer but rejected, query closed by an ignored beat
    probe_q.push_back('{mk(8192, 0, 0, 0, 16384, 0, F_VALID), 1'b0, '0});
    probe_q.push_back('{mk(0, 0, 4096, 0, -16384, 0, F_VALID | F_BACK), 1'b0, '0});
    probe_q.push_back('{mk(0, 0, 0, 0, 0, 0, F_OBJ | F_LAST), 1'b0, '0});
    // normal extremes, the second one flipped with saturation
    probe_q.push_back('{mk(12288, 0, 0, -32768, 32767, -32768, F_VALID), 1'b0, '0});
    probe_q.push_back('{mk(4096, 0, 0, 32767, -32768, 32767, F_VALID | F_LAST),
                        1'b0, '0});
    probe_q.push_back('{mk(-8388608, 8388607, -8388608, 32767, 16384, -32768,
                           F_VALID | F_LAST), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_q[i]) send_item(probe_q[i].cand, probe_q[i].typed, probe_q[i].want);
    in_push <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        wait (query_results_q.size() == 0);
        repeat (8) @(posedge clk);
        load_setup(setups[ph]);
      end
      calm = (ph == 2);
      // long receiver hold-off so the input side backs up
      if (ph == 4) hold_pending = 1'b1;
      run_queries(PHASE_ITEMS);
    end

    wait (query_results_q.size() == 0);
    repeat (20) @(posedge clk);
    errors += query_results_q.size();
    if (errors == 0) begin
      $display("ray_hit_closest_valid_select_tb: clean");
    end else begin
      $display("ray_hit_closest_valid_select_tb: errors");
    end
    $finish;
  end

endmodule
